// ----- rtl/core/chni_pkg.sv -----
// ----------------------------------------------------------------------------
// Color histogram neighborhood information package
// Shared types, field widths, codes and constants of the histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package chni_pkg;

   localparam int CHANNEL_BITS_DEF = 6;
   localparam int COUNT_BITS_DEF   = 24;

   localparam int CHAN_W   = 6;
   localparam int DIST_W   = 6;
   localparam int STATUS_W = 3;
   localparam int INFO_W   = 21;
   localparam int MEAN_W   = 14;
   localparam int MEAN_FRAC = 8;
   localparam int MEAN_STEPS = MEAN_W;
   localparam int LOG_FRAC_W = 32;
   localparam int LOG_INT_W  = 5;
   localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
   localparam int LN2_W      = 24;
   localparam int INFO_SHIFT = 40;
   localparam int PROD_W     = LOG_W + LN2_W;

   localparam logic [LN2_W-1:0]  LN2_Q24  = 24'd11629080;
   localparam logic [INFO_W-1:0] INFO_MAX = {INFO_W{1'b1}};
   localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_DIST  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

   typedef struct packed {
      logic              op;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [DIST_W-1:0] distance;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INFO_W-1:0]   info_value;
      logic [MEAN_W-1:0]   mean_red;
      logic [MEAN_W-1:0]   mean_green;
      logic [MEAN_W-1:0]   mean_blue;
   } rsp_type;

   typedef enum logic [1:0] {
      CLS_ADD,
      CLS_ZERO_DIST,
      CLS_QUERY
   } class_type;

   typedef struct packed {
      logic      valid;
      class_type cls;
      req_type   item;
   } queue_head_type;

   typedef enum logic [1:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_MUL,
      LOG_SQ
   } log_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef enum logic [4:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ADD_RD,
      BK_ADD_WR,
      BK_SETUP,
      BK_WALK,
      BK_DRAIN,
      BK_CHECK,
      BK_LOG_T_GO,
      BK_LOG_T_WAIT,
      BK_LOG_C_GO,
      BK_LOG_C_WAIT,
      BK_INFO_MUL,
      BK_INFO_SH,
      BK_MEAN_GO,
      BK_MEAN_WAIT,
      BK_RESP
   } back_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/chni_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chni_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/chni_front.sv -----
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module chni_front
   import chni_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire req_type        req_data,
   output logic                busy,
   input  wire logic           clear_done,
   output queue_head_type      head,
   input  wire logic           pop
);

   typedef struct packed {
      class_type cls;
      req_type   item;
   } entry_type;

   entry_type  entry_ff [2];
   logic [1:0] fill_ff, fill_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;
   class_type  cls;

   assign busy = !clear_done || (fill_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      if (req_data.op == OP_ADD) begin
         cls = CLS_ADD;
      end else if (req_data.distance == '0) begin
         cls = CLS_ZERO_DIST;
      end else begin
         cls = CLS_QUERY;
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   assign head = '{valid: fill_ff != 2'd0,
                   cls:   entry_ff[rd_ptr_ff].cls,
                   item:  entry_ff[rd_ptr_ff].item};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{cls: cls, item: req_data};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/chni_log.sv -----
// ----------------------------------------------------------------------------
// Iterative base-two logarithm
// Normalizes one bit a cycle, then squares the mantissa for 32 fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module chni_log
   import chni_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire logic [COUNT_BITS-1:0] x,
   output logic                       done,
   output logic [LOG_W-1:0]           result
);

   log_state_type          state_ff, state_in;
   logic [COUNT_BITS-1:0]  x_ff, x_in;
   logic [LOG_INT_W-1:0]   n_ff, n_in;
   logic [31:0]            y_ff, y_in;
   logic [63:0]            prod_ff, prod_in;
   logic [LOG_FRAC_W-1:0]  frac_ff, frac_in;
   logic [4:0]             it_ff, it_in;
   logic [32:0]            sq;
   logic                   done_ff;

   assign result = {n_ff, frac_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      n_ff    <= n_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      frac_ff <= frac_in;
      it_ff   <= it_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      n_in     = n_ff;
      y_in     = y_ff;
      prod_in  = prod_ff;
      frac_in  = frac_ff;
      it_in    = it_ff;
      sq       = prod_ff[63:31];
      unique case (state_ff)
         LOG_IDLE: begin
            if (go) begin
               x_in     = x;
               n_in     = LOG_INT_W'(COUNT_BITS - 1);
               state_in = LOG_NORM;
            end
         end
         LOG_NORM: begin
            if (x_ff[COUNT_BITS-1]) begin
               y_in     = 32'(x_ff) << (32 - COUNT_BITS);
               it_in    = '0;
               frac_in  = '0;
               state_in = LOG_MUL;
            end else begin
               x_in = x_ff << 1;
               n_in = n_ff - 1'b1;
            end
         end
         LOG_MUL: begin
            prod_in  = y_ff * y_ff;
            state_in = LOG_SQ;
         end
         LOG_SQ: begin
            if (sq[32]) begin
               y_in = sq[32:1];
            end else begin
               y_in = sq[31:0];
            end
            frac_in = {frac_ff[LOG_FRAC_W-2:0], sq[32]};
            it_in   = it_ff + 1'b1;
            if (it_ff == 5'd31) begin
               state_in = LOG_IDLE;
            end else begin
               state_in = LOG_MUL;
            end
         end
         default: state_in = LOG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == LOG_SQ) && (it_ff == 5'd31);
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

// ----- rtl/core/chni_div.sv -----
// ----------------------------------------------------------------------------
// Serial mean divider
// Forms floor(sum * 256 / total) one quotient bit a cycle, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module chni_div
   import chni_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               go,
   input  wire logic [COUNT_BITS+CHANNEL_BITS-1:0] sum,
   input  wire logic [COUNT_BITS-1:0]              total,
   output logic                                    done,
   output logic [MEAN_W-1:0]                       quotient
);

   localparam int DIVW = COUNT_BITS + CHANNEL_BITS + MEAN_W;

   div_state_type     state_ff, state_in;
   logic [DIVW-1:0]   n_ff, n_in;
   logic [DIVW-1:0]   d_ff, d_in;
   logic [MEAN_W-1:0] q_ff, q_in;
   logic [3:0]        it_ff, it_in;
   logic [DIVW-1:0]   num;
   logic              fits;

   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff  <= n_in;
      d_ff  <= d_in;
      q_ff  <= q_in;
      it_ff <= it_in;
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      q_in     = q_ff;
      it_in    = it_ff;
      done     = 1'b0;
      num      = DIVW'(sum) << MEAN_FRAC;
      fits     = n_ff >= d_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (go) begin
               n_in  = num;
               d_in  = DIVW'(total) << (MEAN_W - 1);
               q_in  = '0;
               it_in = 4'(MEAN_STEPS - 1);
               if (num >= (DIVW'(total) << MEAN_W)) begin
                  q_in     = MEAN_MAX;
                  state_in = DIV_DONE;
               end else begin
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            if (fits) begin
               n_in = n_ff - d_ff;
            end
            q_in  = {q_ff[MEAN_W-2:0], fits};
            d_in  = d_ff >> 1;
            it_in = it_ff - 1'b1;
            if (it_ff == 4'd0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            done     = 1'b1;
            state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/chni_back.sv -----
// ----------------------------------------------------------------------------
// Histogram back end
// Clears and updates the bin memory, walks query spheres and forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module chni_back
   import chni_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_head_type head,
   output logic                pop,
   output logic                clear_done,
   output logic                rsp_valid,
   output rsp_type             rsp_data
);

   localparam int AW   = 3 * CHANNEL_BITS;
   localparam int SW   = COUNT_BITS + CHANNEL_BITS;
   localparam int CW   = COUNT_BITS + AW;
   localparam int EW   = (CHANNEL_BITS > DIST_W ? CHANNEL_BITS : DIST_W) + 2;
   localparam int DDW  = 2 * CHANNEL_BITS + 2 > 2 * DIST_W ? 2 * CHANNEL_BITS + 2 : 2 * DIST_W;
   localparam logic [COUNT_BITS-1:0]   CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CHANNEL_BITS-1:0] TOP     = {CHANNEL_BITS{1'b1}};

   back_state_type          state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [INFO_W-1:0]       info_ff, info_in;
   logic [MEAN_W-1:0]       mean_ff [3];
   logic [MEAN_W-1:0]       mean_in [3];
   logic [1:0]              chan_ff, chan_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic [SW-1:0]           sum_ff [3];
   logic [SW-1:0]           sum_in [3];
   logic [CW-1:0]           count_ff, count_in;
   logic [CHANNEL_BITS-1:0] pos_ff [3];
   logic [CHANNEL_BITS-1:0] pos_in [3];
   logic [CHANNEL_BITS-1:0] lo_ff [3];
   logic [CHANNEL_BITS-1:0] lo_in [3];
   logic [CHANNEL_BITS-1:0] hi_ff [3];
   logic [CHANNEL_BITS-1:0] hi_in [3];
   logic                    pend_ff, pend_in;
   logic                    inc_ff, inc_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [LOG_W-1:0]        lt_ff, lt_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;

   logic [CHANNEL_BITS-1:0] ctr [3];
   logic [CHANNEL_BITS-1:0] dax [3];
   logic [EW-1:0]           ext_lo, ext_hi;
   logic [DDW-1:0]          dd, dsq;
   logic [AW-1:0]           item_addr;
   logic [COUNT_BITS-1:0]   cnt_clamp;
   logic [LOG_W-1:0]        diff;
   logic [PROD_W:0]         rounded;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [COUNT_BITS-1:0]   ram_wdata;
   logic [AW-1:0]           ram_raddr;
   logic [COUNT_BITS-1:0]   ram_rdata;

   logic                    log_go, log_done;
   logic [COUNT_BITS-1:0]   log_x;
   logic [LOG_W-1:0]        log_res;
   logic                    div_go, div_done;
   logic [MEAN_W-1:0]       div_q;

   chni_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (2 ** AW)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   chni_log #(
      .COUNT_BITS (COUNT_BITS)
   ) u_log (
      .clock  (clock),
      .reset  (reset),
      .go     (log_go),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   chni_div #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .sum      (sum_ff[chan_ff]),
      .total    (total_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign clear_done = state_ff != BK_CLEAR;
   assign rsp_valid  = state_ff == BK_RESP;
   assign rsp_data   = '{status:     status_ff,
                         info_value: info_ff,
                         mean_red:   mean_ff[0],
                         mean_green: mean_ff[1],
                         mean_blue:  mean_ff[2]};

   assign ctr[0]    = CHANNEL_BITS'(item_ff.red);
   assign ctr[1]    = CHANNEL_BITS'(item_ff.green);
   assign ctr[2]    = CHANNEL_BITS'(item_ff.blue);
   assign item_addr = {ctr[0], ctr[1], ctr[2]};
   assign cnt_clamp = (count_ff > CW'(total_ff)) ? total_ff : count_ff[COUNT_BITS-1:0];
   assign diff      = (lt_ff > log_res) ? lt_ff - log_res : '0;
   assign rounded   = (PROD_W+1)'(prod_ff) + ((PROD_W+1)'(1) << (INFO_SHIFT - 1));

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dax[a] = (pos_ff[a] > ctr[a]) ? pos_ff[a] - ctr[a] : ctr[a] - pos_ff[a];
      end
      dd  = DDW'(dax[0] * dax[0]) + DDW'(dax[1] * dax[1]) + DDW'(dax[2] * dax[2]);
      dsq = DDW'(item_ff.distance * item_ff.distance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         total_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         total_ff <= total_in;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= sum_in[a];
         end
      end
      item_ff   <= item_in;
      status_ff <= status_in;
      info_ff   <= info_in;
      chan_ff   <= chan_in;
      count_ff  <= count_in;
      inc_ff    <= inc_in;
      lt_ff     <= lt_in;
      prod_ff   <= prod_in;
      for (int a = 0; a < 3; a++) begin
         mean_ff[a] <= mean_in[a];
         pos_ff[a]  <= pos_in[a];
         lo_ff[a]   <= lo_in[a];
         hi_ff[a]   <= hi_in[a];
      end
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      status_in = status_ff;
      info_in   = info_ff;
      chan_in   = chan_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      clr_in    = clr_ff;
      lt_in     = lt_ff;
      prod_in   = prod_ff;
      pend_in   = 1'b0;
      inc_in    = dd <= dsq;
      for (int a = 0; a < 3; a++) begin
         mean_in[a] = mean_ff[a];
         sum_in[a]  = sum_ff[a];
         pos_in[a]  = pos_ff[a];
         lo_in[a]   = lo_ff[a];
         hi_in[a]   = hi_ff[a];
      end
      ext_lo    = '0;
      ext_hi    = '0;
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = item_addr;
      ram_wdata = ram_rdata + 1'b1;
      ram_raddr = {pos_ff[0], pos_ff[1], pos_ff[2]};
      log_go    = 1'b0;
      log_x     = cnt_clamp;
      div_go    = 1'b0;
      if (pend_ff && inc_ff) begin
         count_in = count_ff + CW'(ram_rdata);
      end
      unique case (state_ff)
         BK_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               item_in   = head.item;
               status_in = ST_OK;
               info_in   = '0;
               chan_in   = 2'd0;
               count_in  = '0;
               unique case (head.cls)
                  CLS_ADD: begin
                     state_in = BK_ADD_RD;
                  end
                  CLS_ZERO_DIST: begin
                     status_in = ST_ZERO_DIST;
                     state_in  = BK_MEAN_GO;
                  end
                  CLS_QUERY: begin
                     if (total_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = BK_MEAN_GO;
                     end else begin
                        state_in = BK_SETUP;
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_ADD_RD: begin
            ram_raddr = item_addr;
            state_in  = BK_ADD_WR;
         end
         BK_ADD_WR: begin
            if (ram_rdata == CNT_MAX || total_ff == CNT_MAX) begin
               status_in = ST_SATURATED;
            end else begin
               ram_we   = 1'b1;
               total_in = total_ff + 1'b1;
               for (int a = 0; a < 3; a++) begin
                  sum_in[a] = sum_ff[a] + SW'(ctr[a]);
               end
            end
            state_in = BK_MEAN_GO;
         end
         BK_SETUP: begin
            for (int a = 0; a < 3; a++) begin
               if (EW'(ctr[a]) > EW'(item_ff.distance)) begin
                  ext_lo = EW'(ctr[a]) - EW'(item_ff.distance);
               end else begin
                  ext_lo = '0;
               end
               ext_hi = EW'(ctr[a]) + EW'(item_ff.distance);
               lo_in[a]  = ext_lo[CHANNEL_BITS-1:0];
               pos_in[a] = ext_lo[CHANNEL_BITS-1:0];
               hi_in[a]  = (ext_hi > EW'(TOP)) ? TOP : ext_hi[CHANNEL_BITS-1:0];
            end
            state_in = BK_WALK;
         end
         BK_WALK: begin
            pend_in = 1'b1;
            if (pos_ff[2] != hi_ff[2]) begin
               pos_in[2] = pos_ff[2] + 1'b1;
            end else begin
               pos_in[2] = lo_ff[2];
               if (pos_ff[1] != hi_ff[1]) begin
                  pos_in[1] = pos_ff[1] + 1'b1;
               end else begin
                  pos_in[1] = lo_ff[1];
                  if (pos_ff[0] != hi_ff[0]) begin
                     pos_in[0] = pos_ff[0] + 1'b1;
                  end else begin
                     state_in = BK_DRAIN;
                  end
               end
            end
         end
         BK_DRAIN: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (count_ff == '0) begin
               status_in = ST_ZERO_COUNT;
               info_in   = INFO_MAX;
               state_in  = BK_MEAN_GO;
            end else begin
               state_in = BK_LOG_T_GO;
            end
         end
         BK_LOG_T_GO: begin
            log_go   = 1'b1;
            log_x    = total_ff;
            state_in = BK_LOG_T_WAIT;
         end
         BK_LOG_T_WAIT: begin
            if (log_done) begin
               lt_in    = log_res;
               state_in = BK_LOG_C_GO;
            end
         end
         BK_LOG_C_GO: begin
            log_go   = 1'b1;
            state_in = BK_LOG_C_WAIT;
         end
         BK_LOG_C_WAIT: begin
            if (log_done) begin
               prod_in  = PROD_W'(diff) * PROD_W'(LN2_Q24);
               state_in = BK_INFO_MUL;
            end
         end
         BK_INFO_MUL: begin
            state_in = BK_INFO_SH;
         end
         BK_INFO_SH: begin
            if (rounded[PROD_W:INFO_SHIFT] > (PROD_W+1-INFO_SHIFT)'(INFO_MAX)) begin
               info_in = INFO_MAX;
            end else begin
               info_in = rounded[INFO_SHIFT+INFO_W-1:INFO_SHIFT];
            end
            state_in = BK_MEAN_GO;
         end
         BK_MEAN_GO: begin
            if (total_ff == '0) begin
               for (int a = 0; a < 3; a++) begin
                  mean_in[a] = '0;
               end
               state_in = BK_RESP;
            end else begin
               div_go   = 1'b1;
               state_in = BK_MEAN_WAIT;
            end
         end
         BK_MEAN_WAIT: begin
            if (div_done) begin
               mean_in[chan_ff] = div_q;
               if (chan_ff == 2'd2) begin
                  state_in = BK_RESP;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = BK_MEAN_GO;
               end
            end
         end
         BK_RESP: begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/color_histogram_neighborhood_info_unit.sv -----
// ----------------------------------------------------------------------------
// Color histogram neighborhood information unit
// Keeps a 3-D color histogram and answers neighborhood information queries.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Requests either add one color sample to its bin or ask for the information
// quantity -ln(count/total) of all samples within a sphere around a color.
// The front end classifies each request into a two-entry queue; the back end
// works on one request at a time and produces exactly one result per request.
// Each result is shown on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall, so results are never held back.
// An add does a read-modify-write of its bin, then the three serial mean
// divisions. A query walks its clipped search box one bin per cycle through
// the single read port of the bin memory, up to (2*distance+1)^3 bins, then
// computes two logarithms (one normalization step per leading zero of the
// operand, then 32 squaring steps) and the means.
// After reset the bin memory is cleared one bin per cycle, over all
// 2^(3*CHANNEL_BITS) bins, and busy stays high until the clear is done.
// ----------------------------------------------------------------------------
`default_nettype none

module color_histogram_neighborhood_info_unit
   import chni_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   queue_head_type head;
   logic           pop;
   logic           clear_done;

   chni_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .clear_done (clear_done),
      .head       (head),
      .pop        (pop)
   );

   chni_back #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .clear_done (clear_done),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_SATURATED)
      else $error("status code out of range");

   a_zero_count_info: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_ZERO_COUNT |-> rsp_data.info_value == INFO_MAX)
      else $error("zero count without maximum information value");
`endif

endmodule

`default_nettype wire
